/* design/assert_macros.svh */
// Assertion macros for the RTL of the region set block.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked outside reset only.
`define RSIC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define RSIC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RSIC_ASSERT(lbl, clk, rstn, prop)
`define RSIC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* design/rsic_pkg.sv */
// Package of the region set insert/coalesce block: payload structs,
// result status codes and sequencer states. No dependencies.
`timescale 1ns / 1ps
package rsic_pkg;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OVERLAP = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRNEW,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] region_start;
    logic [23:0] region_length;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic        merged_previous;
    logic        merged_next;
    logic [6:0]  entry_total;
    logic [31:0] byte_total;
  } out_t;

endpackage

/* design/rsic_mem.sv */
// Region table memory: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rsic_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

/* design/region_set_insert_coalesce_core.sv */
// Region set insert/coalesce core: sequencer around the region table memory.
// Depends on rsic_pkg, rsic_mem and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Keeps up to TABLE_DEPTH disjoint regions (start, length) sorted by start in
// one single-port-read, single-port-write memory with a registered read.
// An offered region is taken only while the sequencer is idle. The table is
// scanned from entry 0, one entry per cycle, up to the first start above the
// new start (insert point i); then the decide state checks overlap, full and
// merge and writes a merged entry or an entry appended past the last one. A
// plain insert shifts entries n-1..i up by one and then writes the new entry,
// a two-sided merge shifts entries i+1..n-1 down by one, one entry per cycle
// with read and write overlapped (n = entries held). An empty table skips the
// scan. Every region ends in the done state, which raises the result, and the
// sequencer then returns to idle before it takes the next region. The result
// sits in an output register, so a new region may be offered while it waits.
// No clearing pass after reset: only entries below the count are ever used.
module region_set_insert_coalesce_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rsic_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rsic_pkg::out_t out_data_o
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = ADDR_BITS + 32;
  localparam int CMP_W = ADDR_BITS + 33;

  rsic_pkg::state_e state_q, state_d;

  // item under work
  logic [ADDR_BITS-1:0] pos_q, pos_d;
  logic [23:0]          len_q, len_d;
  // neighbors found by the scan
  logic [ADDR_BITS-1:0] prev_start_q, prev_start_d, next_start_q, next_start_d;
  logic [31:0]          prev_len_q, prev_len_d, next_len_q, next_len_d;
  logic                 has_prev_q, has_prev_d, has_next_q, has_next_d;
  // indices
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d, src_q, src_d;
  logic [CNT_W-1:0]     ins_q, ins_d;
  // block state
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [31:0]          bytes_q, bytes_d;
  // result
  rsic_pkg::status_e    status_q, status_d;
  logic                 mp_q, mp_d, mn_q, mn_d;
  logic                 out_valid_q, out_valid_d;
  rsic_pkg::out_t       out_data_q, out_data_d;

  // memory ports
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [ENT_W-1:0]     wr_data, rd_data;

  rsic_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(ENT_W)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Field views and decide-cycle arithmetic.
  logic [ADDR_BITS+31:0] start_ext;
  logic [ADDR_BITS-1:0]  rd_start, dp, dn;
  logic [31:0]           rd_len;
  logic [CNT_W-1:0]      rd_next;
  logic                  ovl, mp_c, mn_c, full_c;
  logic [33:0]           sum3;
  logic [32:0]           sum_n, sum_p, sum_b;
  logic [31:0]           sat3, sat_n, sat_p, sat_b;
  logic [CNT_W+6:0]      cnt_ext;

  assign start_ext = {{ADDR_BITS{1'b0}}, in_data_i.region_start};
  assign rd_start  = rd_data[ENT_W-1:32];
  assign rd_len    = rd_data[31:0];
  assign rd_next   = CNT_W'(rd_idx_q) + CNT_W'(1);

  assign dp = pos_q - prev_start_q;   // never wraps: prev start <= pos
  assign dn = next_start_q - pos_q;   // never wraps: next start > pos

  assign ovl  = (has_prev_q && (CMP_W'(dp) < CMP_W'(prev_len_q))) ||
                (has_next_q && (CMP_W'(len_q) > CMP_W'(dn)));
  assign mn_c = !ovl && has_next_q && (CMP_W'(len_q) == CMP_W'(dn));
  assign mp_c = !ovl && has_prev_q && (CMP_W'(dp) == CMP_W'(prev_len_q));
  assign full_c = !mn_c && !mp_c && (cnt_q >= CNT_W'(TABLE_DEPTH));

  assign sum3  = 34'(prev_len_q) + 34'(len_q) + 34'(next_len_q);
  assign sum_n = 33'(next_len_q) + 33'(len_q);
  assign sum_p = 33'(prev_len_q) + 33'(len_q);
  assign sum_b = 33'(bytes_q) + 33'(len_q);
  assign sat3  = (sum3[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum3[31:0];
  assign sat_n = sum_n[32] ? 32'hFFFF_FFFF : sum_n[31:0];
  assign sat_p = sum_p[32] ? 32'hFFFF_FFFF : sum_p[31:0];
  assign sat_b = sum_b[32] ? 32'hFFFF_FFFF : sum_b[31:0];

  assign cnt_ext = {7'd0, cnt_q};

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    len_d        = len_q;
    prev_start_d = prev_start_q;
    prev_len_d   = prev_len_q;
    next_start_d = next_start_q;
    next_len_d   = next_len_q;
    has_prev_d   = has_prev_q;
    has_next_d   = has_next_q;
    rd_idx_d     = rd_idx_q;
    src_d        = src_q;
    ins_d        = ins_q;
    cnt_d        = cnt_q;
    bytes_d      = bytes_q;
    status_d     = status_q;
    mp_d         = mp_q;
    mn_d         = mn_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && out_stall_i;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_addr      = '0;

    unique case (state_q)
      rsic_pkg::S_IDLE: begin
        if (in_valid_i) begin
          pos_d      = start_ext[ADDR_BITS-1:0];
          len_d      = in_data_i.region_length;
          has_prev_d = 1'b0;
          has_next_d = 1'b0;
          rd_idx_d   = '0;
          ins_d      = '0;
          state_d    = (cnt_q == '0) ? rsic_pkg::S_DECIDE : rsic_pkg::S_SCAN;
        end
      end
      rsic_pkg::S_SCAN: begin
        if (rd_start <= pos_q) begin
          prev_start_d = rd_start;
          prev_len_d   = rd_len;
          has_prev_d   = 1'b1;
          if (rd_next < cnt_q) begin
            rd_addr  = rd_next[IDX_W-1:0];
            rd_idx_d = rd_next[IDX_W-1:0];
          end else begin
            ins_d   = cnt_q;
            state_d = rsic_pkg::S_DECIDE;
          end
        end else begin
          next_start_d = rd_start;
          next_len_d   = rd_len;
          has_next_d   = 1'b1;
          ins_d        = CNT_W'(rd_idx_q);
          state_d      = rsic_pkg::S_DECIDE;
        end
      end
      rsic_pkg::S_DECIDE: begin
        mp_d    = 1'b0;
        mn_d    = 1'b0;
        state_d = rsic_pkg::S_DONE;
        if (ovl) begin
          status_d = rsic_pkg::STATUS_OVERLAP;
        end else if (full_c) begin
          status_d = rsic_pkg::STATUS_FULL;
        end else begin
          status_d = rsic_pkg::STATUS_OK;
          mp_d     = mp_c;
          mn_d     = mn_c;
          bytes_d  = sat_b;
          if (mn_c && mp_c) begin
            // previous entry swallows the region and the next entry
            wr_en   = 1'b1;
            wr_addr = IDX_W'(ins_q - CNT_W'(1));
            wr_data = {prev_start_q, sat3};
            cnt_d   = cnt_q - CNT_W'(1);
            if ((ins_q + CNT_W'(1)) < cnt_q) begin
              rd_addr = IDX_W'(ins_q + CNT_W'(1));
              src_d   = IDX_W'(ins_q + CNT_W'(1));
              state_d = rsic_pkg::S_SHIFT_DN;
            end
          end else if (mn_c) begin
            wr_en   = 1'b1;
            wr_addr = ins_q[IDX_W-1:0];
            wr_data = {pos_q, sat_n};
          end else if (mp_c) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(ins_q - CNT_W'(1));
            wr_data = {prev_start_q, sat_p};
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
            if (ins_q < cnt_q) begin
              rd_addr = IDX_W'(cnt_q - CNT_W'(1));
              src_d   = IDX_W'(cnt_q - CNT_W'(1));
              state_d = rsic_pkg::S_SHIFT_UP;
            end else begin
              wr_en   = 1'b1;
              wr_addr = ins_q[IDX_W-1:0];
              wr_data = {pos_q, 32'(len_q)};
            end
          end
        end
      end
      rsic_pkg::S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(src_q + 1'b1);
        wr_data = rd_data;
        if (CNT_W'(src_q) == ins_q) begin
          state_d = rsic_pkg::S_WRNEW;
        end else begin
          rd_addr = IDX_W'(src_q - 1'b1);
          src_d   = IDX_W'(src_q - 1'b1);
        end
      end
      rsic_pkg::S_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(src_q - 1'b1);
        wr_data = rd_data;
        // count is already reduced: old last index equals new count
        if (CNT_W'(src_q) == cnt_q) begin
          state_d = rsic_pkg::S_DONE;
        end else begin
          rd_addr = IDX_W'(src_q + 1'b1);
          src_d   = IDX_W'(src_q + 1'b1);
        end
      end
      rsic_pkg::S_WRNEW: begin
        wr_en   = 1'b1;
        wr_addr = ins_q[IDX_W-1:0];
        wr_data = {pos_q, 32'(len_q)};
        state_d = rsic_pkg::S_DONE;
      end
      rsic_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                = 1'b1;
          out_data_d.status          = status_q;
          out_data_d.merged_previous = mp_q;
          out_data_d.merged_next     = mn_q;
          out_data_d.entry_total     = cnt_ext[6:0];
          out_data_d.byte_total      = bytes_q;
          state_d                    = rsic_pkg::S_IDLE;
        end
      end
      default: state_d = rsic_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsic_pkg::S_IDLE;
      cnt_q       <= '0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bytes_q     <= bytes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    len_q        <= len_d;
    prev_start_q <= prev_start_d;
    prev_len_q   <= prev_len_d;
    next_start_q <= next_start_d;
    next_len_q   <= next_len_d;
    has_prev_q   <= has_prev_d;
    has_next_q   <= has_next_d;
    rd_idx_q     <= rd_idx_d;
    src_q        <= src_d;
    ins_q        <= ins_d;
    status_q     <= status_d;
    mp_q         <= mp_d;
    mn_q         <= mn_d;
    out_data_q   <= out_data_d;
  end

  assign in_stall_o  = (state_q != rsic_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // table never holds more than its depth
  `RSIC_ASSERT_ALWAYS(a_cnt_bound, clk_i, cnt_q <= CNT_W'(TABLE_DEPTH))
  // a fresh result only comes out of the done state
  `RSIC_ASSERT(a_res_src, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == rsic_pkg::S_DONE))
  // an accepted region always starts work
  `RSIC_ASSERT(a_acc_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q != rsic_pkg::S_IDLE))
  // upward shift never passes the insert point
  `RSIC_ASSERT(a_shift_up, clk_i, rst_ni, (state_q == rsic_pkg::S_SHIFT_UP) |-> (CNT_W'(src_q) >= ins_q))

endmodule

/* test/region_set_insert_coalesce_core_tb.sv */
// Testbench of region_set_insert_coalesce_core: directed table, fill and chained merges, then random regions.
// Depends on rsic_pkg and the core; results checked against a local table model.
`timescale 1ns / 1ps
module region_set_insert_coalesce_core_tb;

  localparam int DEPTH      = 64;
  localparam int N_RANDOM   = 465;
  localparam int IDLE_LIMIT = 20000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  rsic_pkg::in_t  in_data;
  rsic_pkg::out_t out_data;

  region_set_insert_coalesce_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Local copy of the region table
  logic [31:0] tbl_start [DEPTH];
  logic [31:0] tbl_len   [DEPTH];
  int          tbl_count;
  logic [31:0] bytes_sum;

  rsic_pkg::out_t result_queue [$];
  int   mismatches;
  int   n_checked;
  int   n_merges;
  int   n_full;
  bit   driving_done;

  function automatic logic [31:0] sat32(logic [32:0] a, logic [32:0] b);
    logic [33:0] s;
    s = a + b;
    return (s > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Apply one region to the local table and return the expected result
  function automatic rsic_pkg::out_t insert_region(rsic_pkg::in_t r);
    rsic_pkg::out_t    res;
    int                i;
    logic [31:0]       pos;
    logic [32:0]       len;
    bit                mp, mn;
    rsic_pkg::status_e st;
    pos = r.region_start;
    len = {9'd0, r.region_length};
    i   = 0;
    mp  = 0;
    mn  = 0;
    st  = rsic_pkg::STATUS_OK;
    while (i < tbl_count && tbl_start[i] <= pos) i++;
    if (i > 0 && (pos - tbl_start[i-1]) < tbl_len[i-1]) st = rsic_pkg::STATUS_OVERLAP;
    if (st == rsic_pkg::STATUS_OK && i < tbl_count && len > {1'b0, tbl_start[i] - pos})
      st = rsic_pkg::STATUS_OVERLAP;
    if (st == rsic_pkg::STATUS_OK) begin
      mn = (i < tbl_count) && (len == {1'b0, tbl_start[i] - pos});
      mp = (i > 0) && ((pos - tbl_start[i-1]) == tbl_len[i-1]);
      if (!mn && !mp && tbl_count >= DEPTH) st = rsic_pkg::STATUS_FULL;
    end
    if (st == rsic_pkg::STATUS_OK) begin
      if (mn && mp) begin
        tbl_len[i-1] = sat32(sat32(tbl_len[i-1], len), tbl_len[i]);
        for (int k = i; k < tbl_count - 1; k++) begin
          tbl_start[k] = tbl_start[k+1];
          tbl_len[k]   = tbl_len[k+1];
        end
        tbl_count--;
      end else if (mn) begin
        tbl_start[i] = pos;
        tbl_len[i]   = sat32(tbl_len[i], len);
      end else if (mp) begin
        tbl_len[i-1] = sat32(tbl_len[i-1], len);
      end else begin
        for (int k = tbl_count; k > i; k--) begin
          tbl_start[k] = tbl_start[k-1];
          tbl_len[k]   = tbl_len[k-1];
        end
        tbl_start[i] = pos;
        tbl_len[i]   = len[31:0];
        tbl_count++;
      end
      bytes_sum = sat32(bytes_sum, len);
    end
    if (mp || mn) n_merges++;
    if (st == rsic_pkg::STATUS_FULL) n_full++;
    res.status          = st;
    res.merged_previous = mp;
    res.merged_next     = mn;
    res.entry_total     = tbl_count[6:0];
    res.byte_total      = bytes_sum;
    return res;
  endfunction

  // Directed stimulus; has_exp rows carry a result readable at a glance
  typedef struct {
    logic [31:0]    start;
    logic [23:0]    length;
    bit             has_exp;
    rsic_pkg::out_t exp_res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic rsic_pkg::out_t mk(rsic_pkg::status_e s, bit p, bit n, int cnt,
                                        logic [31:0] b);
    rsic_pkg::out_t o;
    o.status          = s;
    o.merged_previous = p;
    o.merged_next     = n;
    o.entry_total     = cnt[6:0];
    o.byte_total      = b;
    return o;
  endfunction

  task automatic add_row(logic [31:0] s, logic [23:0] l, bit he, rsic_pkg::out_t e);
    dir_row_t r;
    r.start   = s;
    r.length  = l;
    r.has_exp = he;
    r.exp_res = e;
    dir_rows.push_back(r);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive one transfer on the input side after a random gap
  task automatic send_region(logic [31:0] s, logic [23:0] l);
    int gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.region_start  <= s;
    in_data.region_length <= l;
    in_valid              <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_predicted(logic [31:0] s, logic [23:0] l, bit he,
                                rsic_pkg::out_t e);
    rsic_pkg::in_t  r;
    rsic_pkg::out_t p;
    r.region_start  = s;
    r.region_length = l;
    p = insert_region(r);
    if (he && p != e) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row mismatch start=%h len=%h table=%h model=%h", s, l, e, p);
    end
    result_queue.push_back(p);
    send_region(s, l);
  endtask

  // Random region, mostly placed near existing entries so merges and overlaps happen
  task automatic random_region(output logic [31:0] s, output logic [23:0] l);
    int k, mode;
    mode = $urandom_range(0, 9);
    l = (mode == 9) ? 24'($urandom) : 24'($urandom_range(0, 64));
    if (tbl_count == 0 || mode >= 8) begin
      s = $urandom;
    end else begin
      k = $urandom_range(0, tbl_count - 1);
      case (mode) inside
        0, 1: s = tbl_start[k] + tbl_len[k];
        2, 3: begin
          s = tbl_start[k] - l;
        end
        4: s = tbl_start[k];
        5: s = tbl_start[k] + $urandom_range(0, 8);
        default: s = tbl_start[k] + tbl_len[k] + $urandom_range(1, 40);
      endcase
    end
  endtask

  // Receiver with random stalls
  initial begin
    int hold;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      hold = $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        rsic_pkg::out_t e;
        e = result_queue.pop_front();
        n_checked++;
        if (out_data.status !== e.status || out_data.merged_previous !== e.merged_previous ||
            out_data.merged_next !== e.merged_next ||
            out_data.entry_total !== e.entry_total ||
            out_data.byte_total !== e.byte_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", e, out_data);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0]    s;
    logic [23:0]    l;
    rsic_pkg::out_t none;
    none = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    rst_n        = 1'b0;
    tbl_count    = 0;
    bytes_sum    = '0;
    mismatches   = 0;
    n_checked    = 0;
    n_merges     = 0;
    n_full       = 0;
    driving_done = 0;

    // zero-length first, extremes, overlap, equal start, merges both sides
    add_row(32'h0000_1000, 24'd0,       1, mk(rsic_pkg::STATUS_OK, 0, 0, 1, 32'd0));
    add_row(32'h0000_1000, 24'h10,      1, mk(rsic_pkg::STATUS_OK, 1, 0, 1, 32'h10));
    add_row(32'h0000_1008, 24'h4,       1, mk(rsic_pkg::STATUS_OVERLAP, 0, 0, 1, 32'h10));
    add_row(32'h0000_1020, 24'h10,      0, none);
    add_row(32'h0000_1010, 24'h10,      0, none);
    add_row(32'h0000_0FF0, 24'h10,      0, none);
    add_row(32'h0000_0FF8, 24'h4,       0, none);
    add_row(32'hFFFF_FFFF, 24'hFF_FFFF, 0, none);
    add_row(32'hFFFF_FF00, 24'hFF,      0, none);
    add_row(32'h0000_0000, 24'hFF_FFFF, 0, none);
    add_row(32'h00FF_FFFF, 24'h1,       0, none);
    add_row(32'h0000_2000, 24'd0,       0, none);
    add_row(32'h0000_2000, 24'd0,       0, none);
    add_row(32'h8000_0000, 24'hAA_AAAA, 0, none);
    add_row(32'h5555_5555, 24'h55_5555, 0, none);
    add_row(32'h0000_1FFF, 24'h1,       0, none);
    add_row(32'h0000_1050, 24'h8,       0, none);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[j])
      send_predicted(dir_rows[j].start, dir_rows[j].length, dir_rows[j].has_exp,
                     dir_rows[j].exp_res);

    // Fill the table with separated regions to reach the full case
    for (int j = 0; j < DEPTH + 4; j++)
      send_predicted(32'h4000_0000 + j * 32'h100, 24'($urandom_range(1, 16)), 0, none);
    // long regions chained onto the entry at 0x8000_0000, merging into it
    // while the table is full and driving the byte total up
    for (int j = 0; j < 300; j++)
      send_predicted(32'h80AA_AAAA + j * 32'h00FF_FFFF, 24'hFF_FFFF, 0, none);

    for (int j = 0; j < N_RANDOM; j++) begin
      random_region(s, l);
      send_predicted(s, l, 0, none);
    end
    in_valid <= 1'b0;

    driving_done = 1;
    while (result_queue.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
    $display("checked %0d results, %0d merges, %0d full-table rejects",
             n_checked, n_merges, n_full);
    if (mismatches == 0 && result_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
